// ===== rtl/sha1_pkg.sv =====
// ----------------------------------------------------------------------------
// SHA-1 engine package
// Shared types, request layouts, constants and sequencer states.
// ----------------------------------------------------------------------------
package sha1_pkg;

  typedef logic [31:0]        word_t;
  typedef logic [15:0][31:0]  block_t;
  typedef logic [4:0][31:0]   chain_t;

  // input request: one message byte
  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       last;
  } msg_t;

  // output request: one digest word
  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } digest_t;

  // initial chaining value, index 0 is h0
  localparam chain_t SHA1_INIT = {32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE,
                                  32'hEFCDAB89, 32'h67452301};

  localparam word_t K_R0 = 32'h5A827999;
  localparam word_t K_R1 = 32'h6ED9EBA1;
  localparam word_t K_R2 = 32'h8F1BBCDC;
  localparam word_t K_R3 = 32'hCA62C1D6;

  localparam logic [6:0] ROUND_B1   = 7'd20;
  localparam logic [6:0] ROUND_B2   = 7'd40;
  localparam logic [6:0] ROUND_B3   = 7'd60;
  localparam logic [6:0] ROUND_LAST = 7'd79;

  localparam logic [7:0] PAD_BYTE   = 8'h80;
  localparam logic [5:0] BLOCK_LAST = 6'd63;
  localparam logic [2:0] DIGEST_LAST = 3'd4;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DATA_GO,
    ST_DATA_RUN,
    ST_PAD,
    ST_EXTRA_GO,
    ST_EXTRA_RUN,
    ST_FINAL_GO,
    ST_FINAL_RUN,
    ST_OUT
  } state_t;

endpackage

// ===== rtl/sha1_hash_engine_core.sv =====
// ----------------------------------------------------------------------------
// SHA-1 hash engine core
// Byte-wide message input, padding, iterative compression, digest output.
// ----------------------------------------------------------------------------
// A byte request is accepted in idle; the byte that fills a block also runs a
// compression (start, 80 rounds in the shared round unit, chain update).
// A last request adds a padding step and one compression per padding block (one or
// two), then 5 digest requests, one per cycle when not stalled.
// Synchronous reset loads the SHA-1 initial values and clears length and
// position; the block buffer is not cleared.
// ----------------------------------------------------------------------------
module sha1_hash_engine_core import sha1_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    msg_valid,
  output logic    msg_stall,
  input  msg_t    msg,
  output logic    digest_valid,
  input  logic    digest_stall,
  output digest_t digest
);

  state_t      state, state_next;
  chain_t      chain;
  word_t       block_words [16];
  block_t      block_flat;
  logic [63:0] message_bits;
  logic [5:0]  byte_position;
  logic        fin_pending;
  logic [2:0]  out_idx;

  logic        msg_acc, digest_acc, out_done;
  logic        start, done;
  chain_t      work;
  logic        needs_extra;

  // block buffer write controls
  logic        byte_we;
  logic [7:0]  byte_val;
  logic        zero_tail;
  logic        clear_all;
  logic        len_we;

  assign msg_acc     = msg_valid && !msg_stall;
  assign digest_acc  = digest_valid && !digest_stall;
  assign out_done    = digest_acc && (out_idx == DIGEST_LAST);
  assign needs_extra = (byte_position[5:3] == 3'b111);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (msg_valid) begin
          if (msg.byte_valid && byte_position == BLOCK_LAST) begin
            state_next = ST_DATA_GO;
          end else if (msg.last) begin
            state_next = ST_PAD;
          end
        end
      end
      ST_DATA_GO:   state_next = ST_DATA_RUN;
      ST_DATA_RUN: begin
        if (done) state_next = fin_pending ? ST_PAD : ST_IDLE;
      end
      ST_PAD:       state_next = needs_extra ? ST_EXTRA_GO : ST_FINAL_GO;
      ST_EXTRA_GO:  state_next = ST_EXTRA_RUN;
      ST_EXTRA_RUN: begin
        if (done) state_next = ST_FINAL_GO;
      end
      ST_FINAL_GO:  state_next = ST_FINAL_RUN;
      ST_FINAL_RUN: begin
        if (done) state_next = ST_OUT;
      end
      ST_OUT: begin
        if (out_done) state_next = ST_IDLE;
      end
      default:      state_next = ST_IDLE;
    endcase
  end

  // outputs and buffer controls
  always_comb begin
    msg_stall    = 1'b1;
    digest_valid = 1'b0;
    start        = 1'b0;
    byte_we      = 1'b0;
    byte_val     = msg.data_byte;
    zero_tail    = 1'b0;
    clear_all    = 1'b0;
    len_we       = 1'b0;
    case (state)
      ST_IDLE: begin
        msg_stall = 1'b0;
        byte_we   = msg_valid && msg.byte_valid;
      end
      ST_PAD: begin
        byte_we   = 1'b1;
        byte_val  = PAD_BYTE;
        zero_tail = 1'b1;
        len_we    = !needs_extra;
      end
      ST_DATA_GO, ST_EXTRA_GO, ST_FINAL_GO: begin
        start = 1'b1;
      end
      ST_EXTRA_RUN: begin
        clear_all = done;
        len_we    = done;
      end
      ST_OUT: begin
        digest_valid = 1'b1;
      end
      default: begin
        msg_stall = 1'b1;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      chain         <= SHA1_INIT;
      message_bits  <= '0;
      byte_position <= '0;
      fin_pending   <= 1'b0;
      out_idx       <= '0;
    end else begin
      state <= state_next;
      if (msg_acc) begin
        fin_pending <= msg.last;
        if (msg.byte_valid) message_bits <= message_bits + 64'd8;
      end
      if (byte_we) byte_position <= byte_position + 6'd1;
      // chain update after each compression
      if (done) begin
        for (int i = 0; i < 5; i++) begin
          chain[i] <= chain[i] + work[i];
        end
      end
      if (digest_acc && !out_done) out_idx <= out_idx + 3'd1;
      // re-initialize for the next message
      if (out_done) begin
        chain         <= SHA1_INIT;
        message_bits  <= '0;
        byte_position <= '0;
        out_idx       <= '0;
      end
    end
  end

  // block buffer: byte packing, padding tail, length words
  always_ff @(posedge clk) begin
    for (int i = 0; i < 16; i++) begin
      if (len_we && i == 14) begin
        block_words[i] <= message_bits[63:32];
      end else if (len_we && i == 15) begin
        block_words[i] <= message_bits[31:0];
      end else if (clear_all) begin
        block_words[i] <= '0;
      end else if (byte_we && byte_position[5:2] == 4'(i)) begin
        case (byte_position[1:0])
          2'd0:    block_words[i]        <= {byte_val, 24'd0};
          2'd1:    block_words[i][23:16] <= byte_val;
          2'd2:    block_words[i][15:8]  <= byte_val;
          2'd3:    block_words[i][7:0]   <= byte_val;
          default: block_words[i][7:0]   <= byte_val;
        endcase
      end else if (zero_tail && 4'(i) > byte_position[5:2]) begin
        block_words[i] <= '0;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      block_flat[i] = block_words[i];
    end
  end

  sha1_compress u_compress (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .block (block_flat),
    .chain (chain),
    .done  (done),
    .work  (work)
  );

  // digest request
  always_comb begin
    digest.digest_word = chain[out_idx];
    digest.word_index  = out_idx;
    digest.last_word   = (out_idx == DIGEST_LAST);
  end

endmodule

// ===== rtl/sha1_compress.sv =====
// ----------------------------------------------------------------------------
// SHA-1 compression unit
// One round per cycle; message schedule in a 16-word shift line.
// ----------------------------------------------------------------------------
module sha1_compress import sha1_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   start,
  input  block_t block,
  input  chain_t chain,
  output logic   done,
  output chain_t work
);

  word_t      a, b, c, d, e;
  word_t      w [16];
  logic [6:0] round;
  logic       busy;

  word_t f, k, t, w_new;

  // round function and constant by round group
  always_comb begin
    if (round < ROUND_B1) begin
      f = (b & c) | (~b & d);
      k = K_R0;
    end else if (round < ROUND_B2) begin
      f = b ^ c ^ d;
      k = K_R1;
    end else if (round < ROUND_B3) begin
      f = (b & c) | (b & d) | (c & d);
      k = K_R2;
    end else begin
      f = b ^ c ^ d;
      k = K_R3;
    end
    t = {a[26:0], a[31:27]} + f + e + k + w[0];
  end

  // schedule word for round r+16, from fixed taps
  always_comb begin
    w_new = w[13] ^ w[8] ^ w[2] ^ w[0];
    w_new = {w_new[30:0], w_new[31]};
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      round <= '0;
    end else begin
      if (start) begin
        busy  <= 1'b1;
        done  <= 1'b0;
        round <= '0;
      end else if (busy) begin
        if (round == ROUND_LAST) begin
          busy  <= 1'b0;
          done  <= 1'b1;
          round <= '0;
        end else begin
          done  <= 1'b0;
          round <= round + 7'd1;
        end
      end else begin
        done <= 1'b0;
      end
    end
  end

  // working variables and schedule
  always_ff @(posedge clk) begin
    if (start) begin
      a <= chain[0];
      b <= chain[1];
      c <= chain[2];
      d <= chain[3];
      e <= chain[4];
      for (int i = 0; i < 16; i++) begin
        w[i] <= block[i];
      end
    end else if (busy) begin
      a <= t;
      b <= a;
      c <= {b[1:0], b[31:2]};
      d <= c;
      e <= d;
      for (int i = 0; i < 15; i++) begin
        w[i] <= w[i+1];
      end
      w[15] <= w_new;
    end
  end

  assign work = {e, d, c, b, a};

endmodule
